// File: hdl/seven_queue_request_tracker_defines.svh
// Assertion macros shared by the request tracker RTL.
// Included by modules that carry concurrent checks.
`ifndef SEVEN_QUEUE_REQUEST_TRACKER_DEFINES_SVH
`define SEVEN_QUEUE_REQUEST_TRACKER_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define SQRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SQRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sqrt_pkg.sv
// Shared types and codes for the seven queue request tracker.
// No dependencies.
`default_nettype none
package sqrt_pkg;
  localparam int unsigned NQ = 7;

  typedef enum logic [2:0] {
    OP_ENQ_PENDING = 3'd0, OP_ENQ_PRIORITY = 3'd1, OP_POP = 3'd2, OP_RUNNING = 3'd3,
    OP_COMPLETED = 3'd4, OP_TIMEOUT = 3'd5, OP_RETRY = 3'd6, OP_CANCEL = 3'd7
  } op_t;

  localparam logic [2:0] Q_NONE      = 3'd0;
  localparam logic [2:0] Q_PENDING   = 3'd1;
  localparam logic [2:0] Q_RUNNING   = 3'd2;
  localparam logic [2:0] Q_COMPLETED = 3'd3;
  localparam logic [2:0] Q_CANCELLED = 3'd4;
  localparam logic [2:0] Q_TIMEOUT   = 3'd5;
  localparam logic [2:0] Q_RETRY     = 3'd6;
  localparam logic [2:0] Q_PRIORITY  = 3'd7;

  localparam logic [2:0] ST_PENDING   = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_COMPLETED = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_CANCEL = 2'd1;
  localparam logic [1:0] ERR_LINKED = 2'd2;
  localparam logic [1:0] ERR_EMPTY  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic lookup;    // resolve target slot and read its entry
    logic decide;    // evaluate legality, latch plan
    logic unlink;    // unlink the target slot
    logic append;    // append the target slot, update status
    logic respond;   // drive the result strobe
  } sqrt_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic do_unlink;
    logic do_append;
    logic clearing;  // per-slot table clear after reset still running
  } sqrt_sts_t;
endpackage
`default_nettype wire

// File: hdl/sqrt_ctrl.sv
// Sequencer for the request tracker: steps each item through its phases.
// Depends on sqrt_pkg.
`default_nettype none
module sqrt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output sqrt_pkg::sqrt_cmd_t     cmd,
  input  sqrt_pkg::sqrt_sts_t     sts
);
  import sqrt_pkg::*;
  `include "seven_queue_request_tracker_defines.svh"

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_DECIDE = 6'b000100,
    S_UNLINK = 6'b001000,
    S_APPEND = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Pick the next phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start && !sts.clearing) state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.do_unlink) state_nxt = S_UNLINK;
        else if (sts.do_append) state_nxt = S_APPEND;
        else state_nxt = S_RESP;
      end
      S_UNLINK: state_nxt = sts.do_append ? S_APPEND : S_RESP;
      S_APPEND: state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy        = (state_r != S_IDLE) || sts.clearing;
  assign cmd.capture = (state_r == S_IDLE) && start && !sts.clearing;
  assign cmd.lookup  = (state_r == S_LOOKUP);
  assign cmd.decide  = (state_r == S_DECIDE);
  assign cmd.unlink  = (state_r == S_UNLINK);
  assign cmd.append  = (state_r == S_APPEND);
  assign cmd.respond = (state_r == S_RESP);

  `SQRT_ASSERT_NEXT(a_start_busy, clk, rst_n, cmd.capture, busy, "start not taken")
  `SQRT_ASSERT_NEXT(a_resp_idle, clk, rst_n, cmd.respond, !busy, "no return to idle")
  `SQRT_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
endmodule
`default_nettype wire

// File: hdl/sqrt_datapath.sv
// Link tables, membership, status and queue descriptors of the tracker.
// Depends on sqrt_pkg; driven by sqrt_ctrl commands. The per-slot entry table
// is cleared by a pass over all SLOTS entries after reset.
`default_nettype none
module sqrt_datapath #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  sqrt_pkg::sqrt_cmd_t     cmd,
  output sqrt_pkg::sqrt_sts_t     sts,
  input  wire logic [2:0]         in_operation,
  input  wire logic [5:0]         in_request_slot,
  output logic                    out_valid,
  output logic                    out_accepted,
  output logic [1:0]              out_error_code,
  output logic [5:0]              out_result_slot,
  output logic [2:0]              out_slot_status,
  output logic [7:0]              out_slot_retries
);
  import sqrt_pkg::*;
  `include "seven_queue_request_tracker_defines.svh"

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = $clog2(SLOTS + 1);

  // Per-slot memories (links are undefined until written)
  logic [SW-1:0] next_mem [SLOTS];
  logic [SW-1:0] prev_mem [SLOTS];
  // Per-slot entry: membership, status, retry tally
  logic [13:0] ent_mem [SLOTS];
  // Queue descriptors
  logic [SW-1:0] head_r [NQ];
  logic [SW-1:0] tail_r [NQ];
  logic [LW-1:0] len_r  [NQ];

  logic [2:0]    op_r;
  logic [5:0]    req_r;
  logic [SW-1:0] slot_r;
  logic [2:0]    mq_r;
  logic [2:0]    st_r;
  logic [7:0]    rt_r;
  logic [SW-1:0] nx_r, pv_r;
  logic          empty_r;
  logic          unl_r, app_r, ok_r;
  logic [1:0]    err_r;
  logic [2:0]    dstq_r;
  logic [SW-1:0] clr_r;
  logic          clearing_r;

  // Build the table of every 6-bit index modulo SLOTS
  function automatic logic [64*SW-1:0] mod_table();
    logic [64*SW-1:0] t;
    t = '0;
    for (int i = 0; i < 64; i++) t[i*SW +: SW] = SW'(i % SLOTS);
    return t;
  endfunction

  localparam logic [64*SW-1:0] MOD_TAB = mod_table();

  // Reduce the slot index modulo SLOTS
  function automatic logic [SW-1:0] slot_of(input logic [5:0] v);
    return MOD_TAB[32'(v) * SW +: SW];
  endfunction

  logic [SW-1:0] pri_head, pen_head, look_slot;
  logic pri_ne, pen_ne;
  assign pri_head = head_r[Q_PRIORITY - 3'd1];
  assign pen_head = head_r[Q_PENDING - 3'd1];
  assign pri_ne   = len_r[Q_PRIORITY - 3'd1] != '0;
  assign pen_ne   = len_r[Q_PENDING - 3'd1] != '0;
  assign look_slot = (op_r == OP_POP) ? (pri_ne ? pri_head : pen_head) : slot_of(req_r);

  // New status and retry tally for an append
  logic [2:0] a_st;
  logic [7:0] a_rt;
  always_comb begin
    a_st = st_r;
    a_rt = rt_r;
    case (op_r)
      OP_ENQ_PENDING, OP_ENQ_PRIORITY: a_st = ST_PENDING;
      OP_RUNNING:   a_st = ST_RUNNING;
      OP_COMPLETED: a_st = ST_COMPLETED;
      OP_TIMEOUT:   a_st = ST_TIMEOUT;
      OP_CANCEL:    a_st = ST_CANCELLED;
      default: if (rt_r != 8'hFF) a_rt = rt_r + 8'd1;
    endcase
  end

  // Capture item, then resolve slot and read its entry; update status and tally on append
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      req_r <= in_request_slot;
    end
    if (cmd.lookup) begin
      slot_r  <= look_slot;
      {mq_r, st_r, rt_r} <= ent_mem[look_slot];
      nx_r    <= next_mem[look_slot];
      pv_r    <= prev_mem[look_slot];
      empty_r <= (op_r == OP_POP) && !pri_ne && !pen_ne;
    end
    if (cmd.append) begin
      st_r <= a_st;
      rt_r <= a_rt;
    end
  end

  // Legality and plan
  logic p_unl, p_app, p_ok;
  logic [1:0] p_err;
  logic [2:0] p_dst;
  always_comb begin
    p_unl = 1'b0; p_app = 1'b0; p_ok = 1'b1; p_err = ERR_OK; p_dst = Q_NONE;
    case (op_r)
      OP_ENQ_PENDING, OP_ENQ_PRIORITY, OP_RUNNING: begin
        if (mq_r != Q_NONE) begin
          p_ok = 1'b0; p_err = ERR_LINKED;
        end else begin
          p_app = 1'b1;
          p_dst = (op_r == OP_ENQ_PENDING) ? Q_PENDING :
                  (op_r == OP_ENQ_PRIORITY) ? Q_PRIORITY : Q_RUNNING;
        end
      end
      OP_POP: begin
        if (empty_r) begin
          p_ok = 1'b0; p_err = ERR_EMPTY;
        end else p_unl = 1'b1;
      end
      OP_COMPLETED: begin
        if (mq_r != Q_NONE && mq_r != Q_RUNNING && mq_r != Q_PENDING) begin
          p_ok = 1'b0; p_err = ERR_LINKED;
        end else begin
          p_unl = mq_r != Q_NONE; p_app = 1'b1; p_dst = Q_COMPLETED;
        end
      end
      OP_TIMEOUT: begin
        if (mq_r != Q_NONE && mq_r != Q_RUNNING) begin
          p_ok = 1'b0; p_err = ERR_LINKED;
        end else begin
          p_unl = mq_r != Q_NONE; p_app = 1'b1; p_dst = Q_TIMEOUT;
        end
      end
      OP_RETRY: begin
        if (mq_r != Q_NONE && mq_r != Q_RUNNING && mq_r != Q_TIMEOUT) begin
          p_ok = 1'b0; p_err = ERR_LINKED;
        end else begin
          p_unl = mq_r != Q_NONE; p_app = 1'b1; p_dst = Q_RETRY;
        end
      end
      default: begin
        if (mq_r != Q_PENDING && mq_r != Q_RUNNING && mq_r != Q_PRIORITY) begin
          p_ok = 1'b0; p_err = ERR_CANCEL;
        end else begin
          p_unl = 1'b1; p_app = 1'b1; p_dst = Q_CANCELLED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      unl_r <= p_unl; app_r <= p_app; ok_r <= p_ok; err_r <= p_err; dstq_r <= p_dst;
    end
  end

  assign sts.do_unlink = cmd.decide ? p_unl : unl_r;
  assign sts.do_append = cmd.decide ? p_app : app_r;
  assign sts.clearing  = clearing_r;

  // Unlink and append indexes
  logic [2:0] uqi, aqi;
  logic is_head, is_tail, a_ne;
  logic [SW-1:0] a_tail;
  assign uqi     = mq_r - 3'd1;
  assign aqi     = dstq_r - 3'd1;
  assign is_head = head_r[uqi] == slot_r;
  assign is_tail = tail_r[uqi] == slot_r;
  assign a_ne    = len_r[aqi] != '0;
  assign a_tail  = tail_r[aqi];

  // Link memories: one write phase each for unlink and append
  always_ff @(posedge clk) begin
    if (cmd.unlink) begin
      if (!is_head) next_mem[pv_r] <= nx_r;
      if (!is_tail) prev_mem[nx_r] <= pv_r;
    end
    if (cmd.append) begin
      next_mem[slot_r] <= '0;
      prev_mem[slot_r] <= a_ne ? a_tail : '0;
      if (a_ne) next_mem[a_tail] <= slot_r;
    end
  end

  // Queue descriptors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) len_r[i] <= '0;
    end else begin
      if (cmd.unlink) begin
        if (is_head) head_r[uqi] <= nx_r;
        if (is_tail) tail_r[uqi] <= pv_r;
        if (len_r[uqi] != '0) len_r[uqi] <= len_r[uqi] - LW'(1);
      end
      if (cmd.append) begin
        if (!a_ne) head_r[aqi] <= slot_r;
        tail_r[aqi] <= slot_r;
        len_r[aqi]  <= len_r[aqi] + LW'(1);
      end
    end
  end

  // Walk the entry table once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + SW'(1);
      if (clr_r == SW'(SLOTS - 1)) clearing_r <= 1'b0;
    end
  end

  // Per-slot entry writes: clear, drop membership, then append
  always_ff @(posedge clk) begin
    if (clearing_r) ent_mem[clr_r] <= '0;
    else if (cmd.unlink) ent_mem[slot_r] <= {Q_NONE, st_r, rt_r};
    else if (cmd.append) ent_mem[slot_r] <= {dstq_r, a_st, a_rt};
  end

  // Result
  assign out_valid        = cmd.respond;
  assign out_accepted     = ok_r;
  assign out_error_code   = err_r;
  assign out_result_slot  = empty_r ? 6'd0 : 6'(slot_r);
  assign out_slot_status  = empty_r ? 3'd0 : st_r;
  assign out_slot_retries = empty_r ? 8'd0 : rt_r;

  `SQRT_ASSERT_IMP(a_err_ok, clk, rst_n, out_valid, out_accepted == (out_error_code == ERR_OK),
    "accept flag and error code disagree")
  `SQRT_ASSERT_IMP(a_unlink_member, clk, rst_n, cmd.unlink, mq_r != Q_NONE,
    "unlink of a slot in no queue")
  `SQRT_ASSERT_IMP(a_append_free, clk, rst_n, cmd.append,
    dstq_r != Q_NONE && (unl_r || mq_r == Q_NONE), "append of a linked slot")
endmodule
`default_nettype wire

// File: hdl/seven_queue_request_tracker.sv
// Seven queue request tracker: one item is taken while busy is low and start is high,
// and its result strobes on out_valid after the lookup, decide and respond phases,
// plus an unlink and an append phase when the operation needs them; a rejected item
// skips both. busy falls in the cycle after the strobe.
// The receiver cannot stall: each result is present for exactly one cycle. After reset
// busy stays high while the per-slot table is cleared.
`default_nettype none
module seven_queue_request_tracker #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_operation,
  input  wire logic [5:0] in_request_slot,
  output logic            out_valid,
  output logic            out_accepted,
  output logic [1:0]      out_error_code,
  output logic [5:0]      out_result_slot,
  output logic [2:0]      out_slot_status,
  output logic [7:0]      out_slot_retries
);
  import sqrt_pkg::*;

  sqrt_cmd_t cmd;
  sqrt_sts_t sts;

  sqrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  sqrt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_request_slot(in_request_slot),
    .out_valid(out_valid), .out_accepted(out_accepted), .out_error_code(out_error_code),
    .out_result_slot(out_result_slot), .out_slot_status(out_slot_status),
    .out_slot_retries(out_slot_retries)
  );
endmodule
`default_nettype wire

// File: test/tb_seven_queue_request_tracker.sv
// Testbench for the seven queue request tracker: directed and random operations.
// Depends on sqrt_pkg and seven_queue_request_tracker; keeps its own queue model.
`timescale 1ns / 1ps
`default_nettype none
module tb_seven_queue_request_tracker;
  import sqrt_pkg::*;

  localparam int NSLOT = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_operation;
  logic [5:0] in_request_slot;
  logic out_valid;
  logic out_accepted;
  logic [1:0] out_error_code;
  logic [5:0] out_result_slot;
  logic [2:0] out_slot_status;
  logic [7:0] out_slot_retries;

  seven_queue_request_tracker #(.SLOTS(NSLOT)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_slot(in_request_slot),
    .out_valid(out_valid), .out_accepted(out_accepted),
    .out_error_code(out_error_code), .out_result_slot(out_result_slot),
    .out_slot_status(out_slot_status), .out_slot_retries(out_slot_retries)
  );

  typedef struct packed {
    logic       accepted;
    logic [1:0] error_code;
    logic [5:0] result_slot;
    logic [2:0] slot_status;
    logic [7:0] slot_retries;
  } outcome_t;

  // Tracker model state
  logic [5:0] nxt_of [NSLOT];
  logic [5:0] prv_of [NSLOT];
  logic [2:0] owner_q [NSLOT];
  logic [2:0] stat_of [NSLOT];
  logic [7:0] tries_of [NSLOT];
  logic [5:0] head_of [8];
  logic [5:0] tail_of [8];
  int         len_of [8];

  outcome_t pending_outcomes[$];
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Abort on a runaway run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void model_clear();
    for (int i = 0; i < NSLOT; i++) begin
      nxt_of[i] = 0; prv_of[i] = 0; owner_q[i] = Q_NONE;
      stat_of[i] = 0; tries_of[i] = 0;
    end
    for (int q = 0; q < 8; q++) begin
      head_of[q] = 0; tail_of[q] = 0; len_of[q] = 0;
    end
  endfunction

  function automatic void link_tail(input logic [2:0] q, input logic [5:0] s);
    nxt_of[s] = 0;
    if (len_of[q] != 0) begin
      prv_of[s] = tail_of[q];
      nxt_of[tail_of[q]] = s;
    end else begin
      prv_of[s] = 0;
      head_of[q] = s;
    end
    tail_of[q] = s;
    len_of[q]++;
    owner_q[s] = q;
  endfunction

  function automatic void unlink_from(input logic [5:0] s);
    logic [2:0] q;
    logic [5:0] nx, pv;
    q = owner_q[s]; nx = nxt_of[s]; pv = prv_of[s];
    if (head_of[q] == s) head_of[q] = nx; else nxt_of[pv] = nx;
    if (tail_of[q] == s) tail_of[q] = pv; else prv_of[nx] = pv;
    nxt_of[s] = 0; prv_of[s] = 0;
    if (len_of[q] != 0) len_of[q]--;
    owner_q[s] = Q_NONE;
  endfunction

  // Apply one operation to the model and return the expected result
  function automatic outcome_t track_op(input logic [2:0] op, input logic [5:0] slot);
    outcome_t r;
    logic [5:0] s;
    logic [2:0] m;
    logic ok;
    logic [1:0] err;
    s = slot; m = owner_q[s]; ok = 1; err = ERR_OK;
    case (op_t'(op))
      OP_ENQ_PENDING, OP_ENQ_PRIORITY: begin
        if (m != Q_NONE) begin ok = 0; err = ERR_LINKED; end
        else begin
          stat_of[s] = ST_PENDING;
          link_tail(op == OP_ENQ_PENDING ? Q_PENDING : Q_PRIORITY, s);
        end
      end
      OP_POP: begin
        if (len_of[Q_PRIORITY] != 0) s = head_of[Q_PRIORITY];
        else if (len_of[Q_PENDING] != 0) s = head_of[Q_PENDING];
        else begin
          r = '0; r.error_code = ERR_EMPTY;
          return r;
        end
        unlink_from(s);
      end
      OP_RUNNING: begin
        if (m != Q_NONE) begin ok = 0; err = ERR_LINKED; end
        else begin stat_of[s] = ST_RUNNING; link_tail(Q_RUNNING, s); end
      end
      OP_COMPLETED: begin
        if (m != Q_NONE && m != Q_RUNNING && m != Q_PENDING) begin
          ok = 0; err = ERR_LINKED;
        end else begin
          if (m != Q_NONE) unlink_from(s);
          stat_of[s] = ST_COMPLETED; link_tail(Q_COMPLETED, s);
        end
      end
      OP_TIMEOUT: begin
        if (m != Q_NONE && m != Q_RUNNING) begin ok = 0; err = ERR_LINKED; end
        else begin
          if (m != Q_NONE) unlink_from(s);
          stat_of[s] = ST_TIMEOUT; link_tail(Q_TIMEOUT, s);
        end
      end
      OP_RETRY: begin
        if (m != Q_NONE && m != Q_RUNNING && m != Q_TIMEOUT) begin
          ok = 0; err = ERR_LINKED;
        end else begin
          if (m != Q_NONE) unlink_from(s);
          if (tries_of[s] != 8'hFF) tries_of[s]++;
          link_tail(Q_RETRY, s);
        end
      end
      default: begin
        if (m != Q_PENDING && m != Q_RUNNING && m != Q_PRIORITY) begin
          ok = 0; err = ERR_CANCEL;
        end else begin
          unlink_from(s);
          stat_of[s] = ST_CANCELLED; link_tail(Q_CANCELLED, s);
        end
      end
    endcase
    r.accepted = ok; r.error_code = err; r.result_slot = s;
    r.slot_status = stat_of[s]; r.slot_retries = tries_of[s];
    return r;
  endfunction

  // Send one item after a gap, predict its result at acceptance
  task automatic send_item(input logic [2:0] op, input logic [5:0] slot, input int gap);
    repeat (gap + 1) @(posedge clk);
    start <= 1; in_operation <= op; in_request_slot <= slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outcomes.push_back(track_op(op, slot));
    start <= 0;
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        w = pending_outcomes.pop_front();
        if (out_accepted !== w.accepted)
          report_mismatch("accepted", out_accepted, w.accepted);
        if (out_error_code !== w.error_code)
          report_mismatch("error_code", out_error_code, w.error_code);
        if (out_result_slot !== w.result_slot)
          report_mismatch("result_slot", out_result_slot, w.result_slot);
        if (out_slot_status !== w.slot_status)
          report_mismatch("slot_status", out_slot_status, w.slot_status);
        if (out_slot_retries !== w.slot_retries)
          report_mismatch("slot_retries", out_slot_retries, w.slot_retries);
      end
    end
  end

  task automatic drain();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Extremes, every operation and every error code
  task automatic test_directed();
    send_item(OP_POP, 6'd63, 0);         // both queues empty
    send_item(OP_CANCEL, 6'd0, 0);        // not cancellable
    send_item(OP_ENQ_PENDING, 6'd0, 0);
    send_item(OP_ENQ_PENDING, 6'd63, 0);
    send_item(OP_ENQ_PENDING, 6'd0, 0);   // still linked
    send_item(OP_ENQ_PRIORITY, 6'd5, 0);
    send_item(OP_POP, 6'd0, 0);           // priority first
    send_item(OP_RUNNING, 6'd10, 0);
    send_item(OP_RUNNING, 6'd11, 0);
    send_item(OP_RUNNING, 6'd12, 0);
    send_item(OP_TIMEOUT, 6'd11, 0);      // unlink from the middle
    send_item(OP_RETRY, 6'd11, 0);
    send_item(OP_RETRY, 6'd12, 0);        // unlink the tail
    send_item(OP_COMPLETED, 6'd10, 0);
    send_item(OP_COMPLETED, 6'd63, 0);    // from pending
    send_item(OP_CANCEL, 6'd0, 0);
    send_item(OP_TIMEOUT, 6'd0, 0);       // cancelled slot is linked
    send_item(OP_POP, 6'd0, 0);
    send_item(OP_RETRY, 6'd20, 0);        // retry an idle slot
    drain();
  endtask

  // A slot in the retry queue stays there and keeps its count
  task automatic test_retry_sink();
    send_item(OP_RUNNING, 6'd40, 0);
    send_item(OP_RETRY, 6'd40, 0);        // from running
    send_item(OP_RETRY, 6'd40, 0);        // already in retry
    send_item(OP_COMPLETED, 6'd40, 0);
    send_item(OP_CANCEL, 6'd40, 0);
    send_item(OP_TIMEOUT, 6'd41, 0);      // timeout of an idle slot
    send_item(OP_RETRY, 6'd41, 0);        // from timeout
    drain();
  endtask

  // Random lifecycles with burst/gap idling
  task automatic test_random();
    int burst, gap;
    logic [2:0] op;
    logic [5:0] slot;
    burst = 0;
    for (int i = 0; i < 1700; i++) begin
      gap = 0;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst--;
      slot = (i < 1200) ? 6'($urandom_range(0, 15)) : 6'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        // follow the slot's plausible next step
        case (owner_q[slot])
          Q_NONE:    op = 3'($urandom_range(0, 1)) | ($urandom_range(0, 2) == 0 ? 3'd3 : 3'd0);
          Q_PENDING, Q_PRIORITY:
                     op = ($urandom_range(0, 1)) ? OP_POP : 3'($urandom_range(4, 7));
          Q_RUNNING: op = 3'($urandom_range(4, 7));
          Q_TIMEOUT: op = ($urandom_range(0, 1)) ? OP_RETRY : OP_CANCEL;
          default:   op = 3'($urandom);
        endcase
      end else begin
        op = 3'($urandom);
      end
      send_item(op, slot, gap);
      if (i == 800) drain();
    end
  endtask

  initial begin
    start = 0; in_operation = '0; in_request_slot = '0;
    rst_n = 0;
    model_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_retry_sink();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
